FILE: src/sfb_pkg.sv
package sfb_pkg;

  localparam int unsigned NumSteps = 11;

  // Frame steps, in emission order
  localparam logic [3:0] STEP_SYNC_OPEN  = 4'd0;
  localparam logic [3:0] STEP_HDR_TYPE   = 4'd1;
  localparam logic [3:0] STEP_DST_LO     = 4'd2;
  localparam logic [3:0] STEP_DST_HI     = 4'd3;
  localparam logic [3:0] STEP_MSG_TYPE   = 4'd4;
  localparam logic [3:0] STEP_GROUP      = 4'd5;
  localparam logic [3:0] STEP_LEN        = 4'd6;
  localparam logic [3:0] STEP_DATA       = 4'd7;
  localparam logic [3:0] STEP_TRAIL0     = 4'd8;
  localparam logic [3:0] STEP_TRAIL1     = 4'd9;
  localparam logic [3:0] STEP_SYNC_CLOSE = 4'd10;

  // Configuration register indexes
  localparam logic [2:0] REG_DESTINATION  = 3'd0;
  localparam logic [2:0] REG_SYNC_ENABLE  = 3'd1;
  localparam logic [2:0] REG_FRAME_TYPE   = 3'd2;
  localparam logic [2:0] REG_MESSAGE_TYPE = 3'd3;
  localparam logic [2:0] REG_GROUP_ID     = 3'd4;
  localparam logic [2:0] REG_SYNC_BYTE    = 3'd5;

  localparam logic [15:0] RST_DESTINATION  = 16'hFFFF;
  localparam logic        RST_SYNC_ENABLE  = 1'b1;
  localparam logic [7:0]  RST_FRAME_TYPE   = 8'd66;
  localparam logic [7:0]  RST_MESSAGE_TYPE = 8'd0;
  localparam logic [7:0]  RST_GROUP_ID     = 8'd125;
  localparam logic [7:0]  RST_SYNC_BYTE    = 8'd126;

  localparam logic [7:0] ESC_FLAG   = 8'h7E;
  localparam logic [7:0] ESC_MARK   = 8'h7D;
  localparam logic [7:0] ESC_TOGGLE = 8'h20;

  typedef struct packed {
    logic [NumSteps-1:0] mask;
    logic [7:0]          data;
    logic [7:0]          len;
    logic                last;
  } sfb_entry_t;

  typedef struct packed {
    logic [15:0] destination;
    logic [7:0]  frame_type;
    logic [7:0]  message_type;
    logic [7:0]  group_id;
    logic [7:0]  sync_byte;
  } sfb_cfg_t;

endpackage

FILE: src/serial_frame_builder_byte_stuffing.sv
// Byte-stuffing serial frame builder.
// Input channel (in_valid_i/in_ready_o) takes one transaction per payload
// byte; first_item_i opens a frame (optional sync byte plus six-byte
// header), last_item_i closes it (two zero trailer bytes plus optional sync).
// Header and payload bytes equal to 0x7E or 0x7D are escaped as two bytes.
// Output channel (out_valid_o/out_ready_i) carries one frame byte per
// transaction; end_of_run_o marks the last byte caused by an input
// transaction and end_of_frame_o the last byte of the frame.
// A transaction's first byte goes out via the queue and the output register.
// The output sequencer emits one byte per cycle while the receiver is ready,
// so a payload transaction yields one byte, or two when escaped; a first one
// yields up to 15 bytes, a last one up to 5 and one that is both up to 18.
// The input side keeps accepting into a QDepth-entry queue. Reset clears the
// queue and the output valid flag and restores the register defaults. When
// the receiver stalls, the output byte holds, the queue fills and in_ready_o
// drops. Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) takes effect at
// once; the user must write it only while idle, unenforced by the block.
module serial_frame_builder_byte_stuffing
  import sfb_pkg::*;
#(
  parameter int unsigned QDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_data_i,
  input  logic        first_item_i,
  input  logic        last_item_i,
  input  logic [7:0]  msg_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic        end_of_run_o,
  output logic        end_of_frame_o
);

  sfb_cfg_t   cfg_q;
  logic       sync_enable_q;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  sfb_entry_t q_in;
  sfb_entry_t q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.destination  <= RST_DESTINATION;
      cfg_q.frame_type   <= RST_FRAME_TYPE;
      cfg_q.message_type <= RST_MESSAGE_TYPE;
      cfg_q.group_id     <= RST_GROUP_ID;
      cfg_q.sync_byte    <= RST_SYNC_BYTE;
      sync_enable_q      <= RST_SYNC_ENABLE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DESTINATION:  cfg_q.destination  <= cfg_data_i;
        REG_SYNC_ENABLE:  sync_enable_q      <= cfg_data_i[0];
        REG_FRAME_TYPE:   cfg_q.frame_type   <= cfg_data_i[7:0];
        REG_MESSAGE_TYPE: cfg_q.message_type <= cfg_data_i[7:0];
        REG_GROUP_ID:     cfg_q.group_id     <= cfg_data_i[7:0];
        REG_SYNC_BYTE:    cfg_q.sync_byte    <= cfg_data_i[7:0];
        default:          ;
      endcase
    end
  end

  sfb_front u_front (
    .sync_enable_i (sync_enable_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .has_data_i    (has_data_i),
    .first_item_i  (first_item_i),
    .last_item_i   (last_item_i),
    .msg_length_i  (msg_length_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_in)
  );

  sfb_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  sfb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_i         (q_head),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_byte_o   (frame_byte_o),
    .end_of_run_o   (end_of_run_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

FILE: src/sfb_front.sv
module sfb_front
  import sfb_pkg::*;
(
  input  logic       sync_enable_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       has_data_i,
  input  logic       first_item_i,
  input  logic       last_item_i,
  input  logic [7:0] msg_length_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output sfb_entry_t q_entry_o
);

  logic [NumSteps-1:0] mask;

  // Mark every frame step this transaction asks for
  always_comb begin
    mask = '0;
    mask[STEP_SYNC_OPEN]  = first_item_i & sync_enable_i;
    mask[STEP_HDR_TYPE]   = first_item_i;
    mask[STEP_DST_LO]     = first_item_i;
    mask[STEP_DST_HI]     = first_item_i;
    mask[STEP_MSG_TYPE]   = first_item_i;
    mask[STEP_GROUP]      = first_item_i;
    mask[STEP_LEN]        = first_item_i;
    mask[STEP_DATA]       = has_data_i;
    mask[STEP_TRAIL0]     = last_item_i;
    mask[STEP_TRAIL1]     = last_item_i;
    mask[STEP_SYNC_CLOSE] = last_item_i & sync_enable_i;
  end

  assign in_ready_o     = ~q_full_i;
  assign q_push_o       = in_valid_i & ~q_full_i;
  assign q_entry_o.mask = mask;
  assign q_entry_o.data = data_byte_i;
  assign q_entry_o.len  = msg_length_i;
  assign q_entry_o.last = last_item_i;

endmodule

FILE: src/sfb_queue.sv
module sfb_queue
  import sfb_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sfb_entry_t push_entry_i,
  input  logic       pop_i,
  output sfb_entry_t head_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sfb_entry_t    mem [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW:0]   count_q, count_d;

  assign full_o  = (count_q == (AW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

FILE: src/sfb_back.sv
module sfb_back
  import sfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sfb_cfg_t   cfg_i,
  input  sfb_entry_t head_i,
  input  logic       q_empty_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       end_of_run_o,
  output logic       end_of_frame_o
);

  logic [3:0]          phase_q, phase_d;
  logic                esc_q, esc_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          byte_q, byte_d;
  logic                eor_q, eor_d;
  logic                eof_q, eof_d;

  logic [NumSteps-1:0] below;
  logic [NumSteps-1:0] rem;
  logic [3:0]          cur;
  logic                found;
  logic                more;
  logic [7:0]          raw;
  logic                need_esc;
  logic                advance;

  // Steps still pending for the head transaction
  assign below = (NumSteps'(1) << phase_q) - NumSteps'(1);
  assign rem   = head_i.mask & ~below;
  assign found = |rem;
  assign more  = |(rem & (rem - NumSteps'(1)));

  always_comb begin
    cur = '0;
    for (int i = NumSteps - 1; i >= 0; i--) begin
      if (rem[i]) begin
        cur = 4'(i);
      end
    end
  end

  always_comb begin
    case (cur)
      STEP_SYNC_OPEN, STEP_SYNC_CLOSE: raw = cfg_i.sync_byte;
      STEP_HDR_TYPE:                   raw = cfg_i.frame_type;
      STEP_DST_LO:                     raw = cfg_i.destination[7:0];
      STEP_DST_HI:                     raw = cfg_i.destination[15:8];
      STEP_MSG_TYPE:                   raw = cfg_i.message_type;
      STEP_GROUP:                      raw = cfg_i.group_id;
      STEP_LEN:                        raw = head_i.len;
      STEP_DATA:                       raw = head_i.data;
      default:                         raw = 8'h00;
    endcase
  end

  // Sync and trailer bytes go out unescaped
  assign need_esc = (cur >= STEP_HDR_TYPE) && (cur <= STEP_DATA) &&
                    ((raw == ESC_FLAG) || (raw == ESC_MARK));

  assign advance = ~q_empty_i & (~out_valid_q | out_ready_i);

  always_comb begin
    phase_d     = phase_q;
    esc_d       = esc_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    byte_d      = byte_q;
    eor_d       = eor_q;
    eof_d       = eof_q;
    q_pop_o     = 1'b0;
    if (advance) begin
      if (!found) begin
        // Transaction with nothing to send: drop it
        q_pop_o = 1'b1;
        phase_d = '0;
      end else if (need_esc && !esc_q) begin
        out_valid_d = 1'b1;
        byte_d      = ESC_MARK;
        eor_d       = 1'b0;
        eof_d       = 1'b0;
        esc_d       = 1'b1;
      end else begin
        out_valid_d = 1'b1;
        byte_d      = esc_q ? (raw ^ ESC_TOGGLE) : raw;
        eor_d       = ~more;
        eof_d       = ~more & head_i.last;
        esc_d       = 1'b0;
        if (more) begin
          phase_d = cur + 4'd1;
        end else begin
          phase_d = '0;
          q_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      esc_q       <= esc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    eor_q  <= eor_d;
    eof_q  <= eof_d;
  end

  assign out_valid_o    = out_valid_q;
  assign frame_byte_o   = byte_q;
  assign end_of_run_o   = eor_q;
  assign end_of_frame_o = eof_q;

endmodule
